// File: rtl/skle_pkg.sv
package skle_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths of the stream items
    localparam int OP_BITS    = 3;
    localparam int KEY_BITS   = 32;
    localparam int IDX_BITS   = 5;
    localparam int STAT_BITS  = 3;
    localparam int S_DATA_W   = 48;  // key + position + stop_index, byte padded
    localparam int M_DATA_W   = 48;  // key_out + index_out + count, byte padded

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT    = 3'd0,
        OP_POP_FRONT = 3'd1,
        OP_POP_BACK  = 3'd2,
        OP_FIND      = 3'd3,
        OP_REMOVE    = 3'd4
    } t_op;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADIDX   = 3'd4
    } t_status;

endpackage

// File: rtl/sorted_key_list_engine.sv
// Sorted key list engine. Holds up to DEPTH keys in a two-port store,
// always in order: smallest first, or largest first when the descending_order
// register (written on the cfg channel, only while the block is idle) is set.
// One input item carries an operation in s_axis_tuser (insert, pop front,
// pop back, find over [position, stop_index), remove at index) and gives
// exactly one result item on the m side with status in m_axis_tuser and the
// key, index and new count in m_axis_tdata. Items are handled one at a time:
// s_axis_tready is high only while the engine is idle. Operations walk the
// key store one entry per cycle through its read and write ports, so
// latency is set by that walk: insert walks the whole list, remove walks
// from position to the end (pop front from zero), find from position
// until stop_index or an early stop, pop back reads only the last entry,
// and a rejected or unknown operation walks none. A finished result sits
// in an output register, so the next item is taken while it waits for
// m_axis_tready. No clearing pass runs after reset; the store needs none.
module sorted_key_list_engine #(
    parameter int DEPTH     = skle_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = skle_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: descending_order
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] key, [36:32] position, [41:37] stop_index, [47:42] zero
    input  logic [skle_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] operation
    input  logic [skle_pkg::OP_BITS-1:0]  s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] key_out, [36:32] index_out, [41:37] count, [47:42] zero
    output logic [skle_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [skle_pkg::STAT_BITS-1:0] m_axis_tuser
);
    import skle_pkg::*;

    // Store width: keys are cut to KEY_WIDTH bits, and never exceed the port.
    localparam int SW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // walk counters must hold both count and the 5-bit index fields
    localparam int JW = (CW > IDX_BITS) ? CW : IDX_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    // key store
    logic [SW-1:0] mem [DEPTH];

    // control
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_desc;
    logic          r_pv,    n_pv;      // r_rd holds the entry at r_p
    logic          r_ins,   n_ins;     // insert: new key already placed
    logic          r_m_valid, n_m_valid;

    // payload
    t_op           r_op,    n_op;
    logic [SW-1:0] r_key,   n_key;
    logic [JW-1:0] r_pos,   n_pos;
    logic [JW-1:0] r_stop,  n_stop;
    logic [JW-1:0] r_ra,    n_ra;      // read address being issued
    logic [JW-1:0] r_p,     n_p;       // index of the data in r_rd
    logic [SW-1:0] r_rd;
    logic [SW-1:0] r_carry, n_carry;   // insert: entry displaced one slot up
    t_status       r_status, n_status;
    logic [SW-1:0] r_kout,  n_kout;
    logic [JW-1:0] r_iout,  n_iout;
    t_status       r_m_status, n_m_status;
    logic [KEY_BITS-1:0] r_m_key, n_m_key;
    logic [IDX_BITS-1:0] r_m_idx, n_m_idx;
    logic [IDX_BITS-1:0] r_m_cnt, n_m_cnt;

    // store write port
    logic          w_we;
    logic [JW-1:0] w_wa;
    logic [SW-1:0] w_wd;

    logic [JW-1:0] w_cnt;
    logic          w_pre;   // stored entry goes before the search key
    logic          w_eq;
    logic          s_acc;
    logic [JW-1:0] w_in_pos, w_in_stop;

    assign w_cnt     = JW'(r_count);
    assign w_pre     = r_desc ? (r_rd > r_key) : (r_rd < r_key);
    assign w_eq      = (r_rd == r_key);
    assign s_acc     = s_axis_tvalid && (r_state == S_IDLE);
    assign w_in_pos  = JW'(s_axis_tdata[36:32]);
    assign w_in_stop = JW'(s_axis_tdata[41:37]);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pv       = 1'b0;
        n_ins      = r_ins;
        n_m_valid  = r_m_valid;
        n_op       = r_op;
        n_key      = r_key;
        n_pos      = r_pos;
        n_stop     = r_stop;
        n_ra       = r_ra;
        n_p        = r_p;
        n_carry    = r_carry;
        n_status   = r_status;
        n_kout     = r_kout;
        n_iout     = r_iout;
        n_m_status = r_m_status;
        n_m_key    = r_m_key;
        n_m_idx    = r_m_idx;
        n_m_cnt    = r_m_cnt;
        w_we       = 1'b0;
        w_wa       = r_p;
        w_wd       = r_rd;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_key    = s_axis_tdata[SW-1:0];
                    n_pos    = w_in_pos;
                    n_stop   = w_in_stop;
                    n_status = ST_OK;
                    n_kout   = '0;
                    n_iout   = '0;
                    n_ins    = 1'b0;
                    n_state  = S_WALK;
                    case (s_axis_tuser)
                        OP_INSERT: begin
                            n_op = OP_INSERT;
                            n_ra = '0;
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end
                        end
                        OP_POP_FRONT: begin
                            // same walk as remove at index zero
                            n_op  = OP_REMOVE;
                            n_pos = '0;
                            n_ra  = '0;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end
                        end
                        OP_POP_BACK: begin
                            n_op = OP_POP_BACK;
                            n_ra = w_cnt - 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end
                        end
                        OP_FIND: begin
                            n_op = OP_FIND;
                            n_ra = w_in_pos;
                            if (w_in_pos > w_in_stop || w_in_stop > w_cnt) begin
                                n_status = ST_BADIDX;
                                n_state  = S_FIN;
                            end
                        end
                        OP_REMOVE: begin
                            n_op = OP_REMOVE;
                            n_ra = w_in_pos;
                            if (w_in_pos >= w_cnt) begin
                                n_status = ST_BADIDX;
                                n_state  = S_FIN;
                            end
                        end
                        default: begin
                            n_op    = OP_INSERT;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // issue the next read every cycle; process the data from last
                n_ra = r_ra + 1'b1;
                n_p  = r_ra;
                n_pv = 1'b1;
                if (r_pv) begin
                    case (r_op)
                        OP_INSERT: begin
                            if (r_p == w_cnt) begin
                                // slot past the end: key or last carried entry
                                w_we    = 1'b1;
                                w_wd    = r_ins ? r_carry : r_key;
                                if (!r_ins) begin
                                    n_iout = r_p;
                                end
                                n_count = r_count + 1'b1;
                                n_state = S_FIN;
                            end else if (!r_ins && !w_pre) begin
                                w_we    = 1'b1;
                                w_wd    = r_key;
                                n_carry = r_rd;
                                n_ins   = 1'b1;
                                n_iout  = r_p;
                            end else if (r_ins) begin
                                w_we    = 1'b1;
                                w_wd    = r_carry;
                                n_carry = r_rd;
                            end
                        end
                        OP_POP_BACK: begin
                            n_kout  = r_rd;
                            n_iout  = r_p;
                            n_count = r_count - 1'b1;
                            n_state = S_FIN;
                        end
                        OP_FIND: begin
                            if (r_p == r_stop) begin
                                n_status = ST_NOTFOUND;
                                n_iout   = r_stop;
                                n_state  = S_FIN;
                            end else if (!w_pre) begin
                                if (w_eq) begin
                                    n_kout = r_rd;
                                    n_iout = r_p;
                                end else begin
                                    n_status = ST_NOTFOUND;
                                    n_iout   = r_stop;
                                end
                                n_state = S_FIN;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_p == r_pos) begin
                                n_kout = r_rd;
                                n_iout = r_pos;
                            end else begin
                                // close the gap: move entry one slot down
                                w_we = 1'b1;
                                w_wa = r_p - 1'b1;
                            end
                            if (r_p == w_cnt - 1'b1) begin
                                n_count = r_count - 1'b1;
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_key    = KEY_BITS'(r_kout);
                    n_m_idx    = r_iout[IDX_BITS-1:0];
                    n_m_cnt    = IDX_BITS'(r_count);
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_desc    <= 1'b0;
            r_pv      <= 1'b0;
            r_ins     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_ins     <= n_ins;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_stop     <= n_stop;
        r_ra       <= n_ra;
        r_p        <= n_p;
        r_carry    <= n_carry;
        r_status   <= n_status;
        r_kout     <= n_kout;
        r_iout     <= n_iout;
        r_m_status <= n_m_status;
        r_m_key    <= n_m_key;
        r_m_idx    <= n_m_idx;
        r_m_cnt    <= n_m_cnt;
    end

    // key store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa[IW-1:0]] <= w_wd;
        end
        r_rd <= mem[r_ra[IW-1:0]];
    end

    // order changes only between operations
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{(M_DATA_W - KEY_BITS - 2 * IDX_BITS){1'b0}},
                            r_m_cnt, r_m_idx, r_m_key};

endmodule

// File: rtl/skle_checker.sv
module skle_checker #(
    parameter int DEPTH = skle_pkg::DEPTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [skle_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic [skle_pkg::STAT_BITS-1:0] m_axis_tuser
);
    import skle_pkg::*;

    // one item in flight: intake closes right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // full is only reported with the store at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |->
            (DEPTH >= 32 || m_axis_tdata[41:37] == 5'(DEPTH)))
        else $error("full reported below capacity");

    // failed operations return no key
    a_fail_nokey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_EMPTY ||
            m_axis_tuser == ST_NOTFOUND)) |-> m_axis_tdata[31:0] == '0)
        else $error("key returned on failed operation");

    // rejected index: key and index both zero
    a_badidx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_BADIDX) |-> m_axis_tdata[36:0] == '0)
        else $error("bad index result not cleared");

endmodule

bind sorted_key_list_engine skle_checker #(
    .DEPTH(DEPTH)
) u_skle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/sorted_key_list_engine_tb.sv
`timescale 1ns / 100ps

module sorted_key_list_engine_tb;
    import skle_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 104;
    localparam int SETTLE_CYCLES = 24;     // covers the longest walk
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd5;   // codes the block ignores
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic [31:0]        key;
        logic [4:0]         pos;
        logic [4:0]         stop;
    } list_req_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] key;
        logic [4:0]  index;
        logic [4:0]  count;
    } list_reply_t;

    typedef struct packed {
        list_req_t   req;
        bit          typed;
        list_reply_t want;
    } plan_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_data = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_BITS-1:0]    s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [STAT_BITS-1:0]  m_axis_tuser;

    // model of the sorted list, touched only by the source process
    logic [31:0] list_keys [LIST_DEPTH];
    int          list_len = 0;
    bit          order_desc = 1'b0;

    list_reply_t replies_due [$];
    plan_row_t   plan [22];
    int          fail_count = 0;
    int          gap_pct = 20;
    int          rx_stall_pct = 20;
    bit          hold_request = 1'b0;

    sorted_key_list_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit comes_first(input logic [31:0] a, input logic [31:0] b);
        return order_desc ? (a > b) : (a < b);
    endfunction

    // applies one operation to the list model and returns its reply
    function automatic list_reply_t apply_to_list(input list_req_t r);
        list_reply_t o;
        int i;
        int j;
        o.status = ST_OK;
        o.key = '0;
        o.index = '0;
        case (r.op)
            OP_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    i = 0;
                    // new key lands ahead of equal keys
                    while (i < list_len && comes_first(list_keys[i], r.key)) i++;
                    for (j = list_len; j > i; j--) list_keys[j] = list_keys[j-1];
                    list_keys[i] = r.key;
                    list_len++;
                    o.index = 5'(i);
                end
            end
            OP_POP_FRONT: begin
                if (list_len == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.key = list_keys[0];
                    for (j = 0; j < list_len - 1; j++) list_keys[j] = list_keys[j+1];
                    list_len--;
                end
            end
            OP_POP_BACK: begin
                if (list_len == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    list_len--;
                    o.key = list_keys[list_len];
                    o.index = 5'(list_len);
                end
            end
            OP_FIND: begin
                if (r.pos > r.stop || r.stop > list_len) begin
                    o.status = ST_BADIDX;
                end else begin
                    i = r.pos;
                    while (i < r.stop && comes_first(list_keys[i], r.key)) i++;
                    if (i < r.stop && !comes_first(r.key, list_keys[i])) begin
                        o.key = list_keys[i];
                        o.index = 5'(i);
                    end else begin
                        o.status = ST_NOTFOUND;
                        o.index = r.stop;
                    end
                end
            end
            OP_REMOVE: begin
                if (r.pos >= list_len) begin
                    o.status = ST_BADIDX;
                end else begin
                    o.key = list_keys[r.pos];
                    for (j = r.pos; j < list_len - 1; j++) list_keys[j] = list_keys[j+1];
                    list_len--;
                    o.index = r.pos;
                end
            end
            default: ;
        endcase
        o.count = 5'(list_len);
        return o;
    endfunction

    function automatic plan_row_t step_row(input logic [OP_BITS-1:0] op,
                                           input logic [31:0] key,
                                           input logic [4:0] pos, input logic [4:0] stop,
                                           input bit typed, input t_status st,
                                           input logic [31:0] k_out,
                                           input logic [4:0] idx, input logic [4:0] cnt);
        plan_row_t p;
        p.req = '{op: op, key: key, pos: pos, stop: stop};
        p.typed = typed;
        p.want = '{status: st, key: k_out, index: idx, count: cnt};
        return p;
    endfunction

    // mix of fresh, small (duplicate-prone), extreme and already stored keys
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2, 3: return 32'($urandom_range(0, 15));
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hffff_ffff;
                    2: return 32'h8000_0000;
                    default: return 32'h7fff_ffff;
                endcase
            end
            default: return (list_len > 0) ? list_keys[$urandom_range(0, list_len - 1)]
                                           : $urandom();
        endcase
    endfunction

    // mostly well-formed requests against the current list, some noise
    function automatic list_req_t pick_request(input int ins_pct);
        list_req_t r;
        int sel;
        r.key = pick_key();
        r.pos = 5'($urandom_range(0, 31));
        r.stop = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < ins_pct) begin
            r.op = OP_INSERT;
        end else begin
            sel = $urandom_range(0, 19);
            if (sel < 4) begin
                r.op = OP_POP_FRONT;
            end else if (sel < 8) begin
                r.op = OP_POP_BACK;
            end else if (sel < 14) begin
                r.op = OP_FIND;
                if ($urandom_range(0, 7) != 0) begin
                    r.stop = 5'($urandom_range(0, list_len));
                    r.pos = 5'($urandom_range(0, r.stop));
                    if (r.pos < r.stop && $urandom_range(0, 1) == 1)
                        r.key = list_keys[$urandom_range(r.pos, r.stop - 1)];
                end
            end else if (sel < 19) begin
                r.op = OP_REMOVE;
                if (list_len > 0 && $urandom_range(0, 7) != 0)
                    r.pos = 5'($urandom_range(0, list_len - 1));
            end else begin
                r.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
        end
        return r;
    endfunction

    task automatic offer(input list_req_t r, input bit typed, input list_reply_t want);
        list_reply_t got;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {6'd0, r.stop, r.pos, r.key};
        do @(posedge i_clk); while (!s_axis_tready);
        got = apply_to_list(r);
        replies_due.push_back(typed ? want : got);
    endtask

    task automatic maybe_gap();
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // stop offering until every reply is back and the engine is quiet
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_order(input bit desc);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= desc;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        order_desc = desc;
    endtask

    initial begin : source
        int ins_pct;
        bit calm;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_order(1'b0);

        // directed: empty list, extremes, duplicates, bad ranges, spare code
        plan = '{
            step_row(OP_POP_FRONT, 32'd0, 5'd0, 5'd0, 1, ST_EMPTY, 32'd0, 5'd0, 5'd0),
            step_row(OP_POP_BACK, 32'd0, 5'd0, 5'd0, 1, ST_EMPTY, 32'd0, 5'd0, 5'd0),
            step_row(OP_FIND, 32'd5, 5'd0, 5'd0, 1, ST_NOTFOUND, 32'd0, 5'd0, 5'd0),
            step_row(OP_FIND, 32'd5, 5'd0, 5'd1, 1, ST_BADIDX, 32'd0, 5'd0, 5'd0),
            step_row(OP_REMOVE, 32'd0, 5'd0, 5'd0, 1, ST_BADIDX, 32'd0, 5'd0, 5'd0),
            step_row(OP_INSERT, 32'hffff_ffff, 5'd0, 5'd0, 1, ST_OK, 32'd0, 5'd0, 5'd1),
            step_row(OP_INSERT, 32'd0, 5'd0, 5'd0, 1, ST_OK, 32'd0, 5'd0, 5'd2),
            step_row(OP_INSERT, 32'h8000_0000, 5'd0, 5'd0, 0, ST_OK, '0, '0, '0),
            step_row(OP_INSERT, 32'h8000_0000, 5'd31, 5'd31, 0, ST_OK, '0, '0, '0),
            step_row(OP_FIND, 32'h8000_0000, 5'd0, 5'd4, 0, ST_OK, '0, '0, '0),
            step_row(OP_FIND, 32'd0, 5'd3, 5'd2, 1, ST_BADIDX, 32'd0, 5'd0, 5'd4),
            step_row(OP_FIND, 32'hffff_ffff, 5'd0, 5'd3, 0, ST_OK, '0, '0, '0),
            step_row(OP_FIND, 32'd7, 5'd4, 5'd4, 0, ST_OK, '0, '0, '0),
            step_row(OP_REMOVE, 32'd0, 5'd16, 5'd0, 1, ST_BADIDX, 32'd0, 5'd0, 5'd4),
            step_row(OP_REMOVE, 32'd0, 5'd31, 5'd0, 1, ST_BADIDX, 32'd0, 5'd0, 5'd4),
            step_row(OP_REMOVE, 32'd0, 5'd1, 5'd0, 0, ST_OK, '0, '0, '0),
            step_row(OP_SPARE_HI, 32'hffff_ffff, 5'd31, 5'd31, 1, ST_OK, 32'd0, 5'd0, 5'd3),
            step_row(OP_POP_BACK, 32'd0, 5'd0, 5'd0, 0, ST_OK, '0, '0, '0),
            step_row(OP_POP_FRONT, 32'd0, 5'd0, 5'd0, 0, ST_OK, '0, '0, '0),
            step_row(OP_FIND, 32'd0, 5'd31, 5'd31, 1, ST_BADIDX, 32'd0, 5'd0, 5'd1),
            step_row(OP_REMOVE, 32'd0, 5'd0, 5'd0, 0, ST_OK, '0, '0, '0),
            step_row(OP_POP_BACK, 32'd0, 5'd0, 5'd0, 1, ST_EMPTY, 32'd0, 5'd0, 5'd0)
        };
        foreach (plan[n]) begin
            offer(plan[n].req, plan[n].typed, plan[n].want);
            maybe_gap();
        end

        // random phases: fill, mixed and drain traffic, order flips between them
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_replies();
            set_order((ph % 2) == 0);
            ins_pct = (ph % 3 == 0) ? 65 : ((ph % 3 == 1) ? 35 : 15);
            calm = (ph % 4 == 3) || (ph == PHASES - 1);
            gap_pct = calm ? 0 : 20;
            rx_stall_pct = calm ? 0 : 20;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long sink stall while requests keep coming
                if (ph == 4 && n == 10) hold_request = 1'b1;
                offer(pick_request(ins_pct), 1'b0, '0);
                maybe_gap();
            end
        end

        drain_replies();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : sink
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        list_reply_t want;
        logic [31:0] got_key;
        logic [4:0]  got_index;
        logic [4:0]  got_count;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_key = m_axis_tdata[31:0];
            got_index = m_axis_tdata[36:32];
            got_count = m_axis_tdata[41:37];
            if (replies_due.size() == 0) begin
                $error("reply with no request outstanding");
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (got_key !== want.key) begin
                    $error("key_out: expected %h, got %h", want.key, got_key);
                    fail_count++;
                end
                if (got_index !== want.index) begin
                    $error("index_out: expected %0d, got %0d", want.index, got_index);
                    fail_count++;
                end
                if (got_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got_count);
                    fail_count++;
                end
            end
        end
    end

    // cycles without any handshake on any channel
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

// File: sorted_key_list_engine.f
rtl/skle_pkg.sv
rtl/sorted_key_list_engine.sv
rtl/skle_checker.sv
sim/sorted_key_list_engine_tb.sv
